/* sv/mbsp_pkg.sv */
// package for the midi byte stream parser: codes, status constants and beat types
`timescale 1ns / 1ps

package mbsp_pkg;

    // event codes carried on the result channel
    typedef enum logic [2:0] {
        EV_NOTE    = 3'd0,
        EV_CC      = 3'd1,
        EV_PC      = 3'd2,
        EV_BEND    = 3'd3,
        EV_SX_DATA = 3'd4,
        EV_SX_END  = 3'd5
    } event_kind_t;

    // whole status bytes with a meaning of their own
    localparam logic [7:0] STATUS_NONE       = 8'h00;
    localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_END  = 8'hF7;

    // upper nibble of channel status bytes
    localparam logic [3:0] NIB_NOTE_OFF      = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON       = 4'h9;
    localparam logic [3:0] NIB_CTRL_CHANGE   = 4'hB;
    localparam logic [3:0] NIB_PROG_CHANGE   = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESSURE = 4'hD;
    localparam logic [3:0] NIB_PITCH_BEND    = 4'hE;

    // byte counter values used while a channel message is assembled
    localparam logic [7:0] CNT_IDLE   = 8'd0;
    localparam logic [7:0] CNT_FIRST  = 8'd1;
    localparam logic [7:0] CNT_SECOND = 8'd2;

    // one result beat
    typedef struct packed {
        event_kind_t kind;
        logic [3:0]  channel;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [7:0]  sysex_index;
    } event_t;

    // decoder result for one byte
    typedef struct packed {
        logic   emit;
        event_t ev;
    } dec_result_t;

endpackage

/* sv/mbsp_byte_if.sv */
// handshake channel carrying one received midi byte per beat
`timescale 1ns / 1ps

interface mbsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;

    modport source (output valid, output midi_byte, input ready);
    modport sink   (input valid, input midi_byte, output ready);
endinterface

/* sv/mbsp_event_if.sv */
// handshake channel carrying one parsed midi event per beat
`timescale 1ns / 1ps

interface mbsp_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [3:0] channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [7:0] sysex_index;

    modport source (output valid, output event_kind, output channel, output first_data,
                    output second_data, output sysex_index, input ready);
    modport sink   (input valid, input event_kind, input channel, input first_data,
                    input second_data, input sysex_index, output ready);
endinterface

/* sv/mbsp_in_stage.sv */
// input register: holds one accepted byte until the decoder takes it
`timescale 1ns / 1ps

module mbsp_in_stage
    import mbsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mbsp_byte_if.sink   byte_stream,
    input  logic        drain,
    output logic        valid_reg,
    output logic [7:0]  byte_reg
);

    logic       valid_next;
    logic [7:0] byte_next;
    logic       load;

    // room when empty or when the held byte moves on this cycle
    assign load              = !valid_reg || drain;
    assign byte_stream.ready = load;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (load)
        begin
            valid_next = byte_stream.valid;
            if (byte_stream.valid)
            begin
                byte_next = byte_stream.midi_byte;
            end
        end
    end

    // control flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

/* sv/mbsp_decode.sv */
// running status decoder: parser state and the event for one byte
`timescale 1ns / 1ps

module mbsp_decode
    import mbsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  midi_byte,
    output dec_result_t res
);

    logic [7:0] running_status_reg, running_status_next;
    logic [7:0] byte_counter_reg,   byte_counter_next;
    logic [6:0] held_first_reg,     held_first_next;
    logic [3:0] status_hi;
    logic [3:0] status_ch;
    logic [6:0] data7;

    // map a completed channel message to an event; channel pressure gives none
    function automatic dec_result_t finish_msg(input logic [3:0] hi, input logic [3:0] ch,
                                               input logic [6:0] d1, input logic [6:0] d2);
        dec_result_t r;
        r                = '0;
        r.ev.channel     = ch;
        r.ev.first_data  = d1;
        unique case (hi)
            NIB_NOTE_OFF:
            begin
                r.emit    = 1'b1;
                r.ev.kind = EV_NOTE;
            end
            NIB_NOTE_ON:
            begin
                r.emit           = 1'b1;
                r.ev.kind        = EV_NOTE;
                r.ev.second_data = d2;
            end
            NIB_CTRL_CHANGE:
            begin
                r.emit           = 1'b1;
                r.ev.kind        = EV_CC;
                r.ev.second_data = d2;
            end
            NIB_PROG_CHANGE:
            begin
                r.emit    = 1'b1;
                r.ev.kind = EV_PC;
            end
            NIB_PITCH_BEND:
            begin
                r.emit           = 1'b1;
                r.ev.kind        = EV_BEND;
                r.ev.second_data = d2;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    assign status_hi = running_status_reg[7:4];
    assign status_ch = running_status_reg[3:0];
    assign data7     = midi_byte[6:0];

    // next state and event for the byte at hand
    always_comb
    begin
        running_status_next = running_status_reg;
        byte_counter_next   = byte_counter_reg;
        held_first_next     = held_first_reg;
        res                 = '0;
        if (midi_byte[7])
        begin
            if (midi_byte == STATUS_SYSEX_END)
            begin
                // sysex end always reported, open or not
                running_status_next = STATUS_NONE;
                byte_counter_next   = CNT_IDLE;
                res.emit            = 1'b1;
                res.ev.kind         = EV_SX_END;
            end
            else
            begin
                running_status_next = midi_byte;
                byte_counter_next   = CNT_FIRST;
            end
        end
        else if (running_status_reg == STATUS_SYSEX)
        begin
            // sysex payload, index wraps with the counter
            byte_counter_next  = byte_counter_reg + 8'd1;
            res.emit           = 1'b1;
            res.ev.kind        = EV_SX_DATA;
            res.ev.first_data  = data7;
            res.ev.sysex_index = byte_counter_reg;
        end
        else if (running_status_reg == STATUS_NONE)
        begin
            res = '0;
        end
        else if (byte_counter_reg <= CNT_FIRST)
        begin
            held_first_next = data7;
            if (status_hi == NIB_PROG_CHANGE || status_hi == NIB_CHAN_PRESSURE)
            begin
                byte_counter_next = CNT_IDLE;
                res               = finish_msg(status_hi, status_ch, data7, 7'd0);
            end
            else
            begin
                byte_counter_next = CNT_SECOND;
            end
        end
        else if (byte_counter_reg == CNT_SECOND)
        begin
            byte_counter_next = CNT_IDLE;
            res               = finish_msg(status_hi, status_ch, held_first_reg, data7);
        end
    end

    // parser state, advanced once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_status_reg <= STATUS_NONE;
            byte_counter_reg   <= CNT_IDLE;
            held_first_reg     <= 7'd0;
        end
        else if (step)
        begin
            running_status_reg <= running_status_next;
            byte_counter_reg   <= byte_counter_next;
            held_first_reg     <= held_first_next;
        end
    end

endmodule

/* sv/mbsp_out_stage.sv */
// result register: holds one event beat until the sink takes it
`timescale 1ns / 1ps

module mbsp_out_stage
    import mbsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  dec_result_t   res,
    output logic          can_load,
    mbsp_event_if.source  event_stream
);

    logic   valid_reg, valid_next;
    event_t ev_reg,    ev_next;

    // free when empty or when the held beat leaves this cycle
    assign can_load = !valid_reg || event_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        ev_next    = ev_reg;
        if (can_load)
        begin
            valid_next = step && res.emit;
            if (step && res.emit)
            begin
                ev_next = res.ev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
    end

    // drive the channel
    assign event_stream.valid       = valid_reg;
    assign event_stream.event_kind  = ev_reg.kind;
    assign event_stream.channel     = ev_reg.channel;
    assign event_stream.first_data  = ev_reg.first_data;
    assign event_stream.second_data = ev_reg.second_data;
    assign event_stream.sysex_index = ev_reg.sysex_index;

endmodule

/* sv/midi_byte_stream_parser_unit.sv */
// midi byte stream parser: top level joining input register, decoder and result register
// an accepted byte is held in the input register and decoded; its event is presented from the result register
// throughput: one byte per cycle; a held byte waits only while the result beat is not taken
// a byte that gives no event leaves nothing on the result channel
// reset: asynchronous active low; clears status, counter, held data and both valid flags
`timescale 1ns / 1ps

module midi_byte_stream_parser_unit
    import mbsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mbsp_byte_if.sink    byte_stream,
    mbsp_event_if.source event_stream
);

    logic        in_valid;
    logic [7:0]  in_byte;
    logic        can_load;
    logic        step;
    dec_result_t res;

    // the held byte is decoded whenever the result register has room
    assign step = in_valid && can_load;

    mbsp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .drain       (can_load),
        .valid_reg   (in_valid),
        .byte_reg    (in_byte)
    );

    mbsp_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .midi_byte (in_byte),
        .res       (res)
    );

    mbsp_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .res          (res),
        .can_load     (can_load),
        .event_stream (event_stream)
    );

endmodule
